FILE: hw/rtl/lpdc_pkg.sv
// ----------------------------------------------------------------------------
// lpdc_pkg
// shared types and constants of the lift position drive controller
// ----------------------------------------------------------------------------
package lpdc_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SEEK_MODE  = 3'd0;
	localparam logic [2:0] REG_TARGET     = 3'd1;
	localparam logic [2:0] REG_MOVE_GAIN  = 3'd2;
	localparam logic [2:0] REG_HOLD_TOL   = 3'd3;
	localparam logic [2:0] REG_SPEED_LIM  = 3'd4;

	// seek modes
	localparam logic [1:0] MODE_TARGET = 2'd0;
	localparam logic [1:0] MODE_BOTTOM = 2'd1;
	localparam logic [1:0] MODE_TOP    = 2'd2;

	// reset values of the registers
	localparam logic [15:0] GAIN_RESET      = 16'd6991;
	localparam logic [15:0] TOL_RESET       = 16'd60;
	localparam logic [15:0] SPEED_LIM_RESET = 16'd2880;

	localparam logic [14:0] FULL_SCALE = 15'h7fff;

	// serial multiplier shape: multiplicand a, multiplier b
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// serial divider shape
	localparam int DIV_N_W = 31;
	localparam int DIV_D_W = 16;
	localparam int DIV_Q_W = 15;

	typedef struct packed {
		logic busy;
		logic last;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_ERR,
		ST_ABS,
		ST_MGO,
		ST_MUL1,
		ST_MAG,
		ST_M2GO,
		ST_MUL2,
		ST_DGO,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/lpdc_mul.sv
// ----------------------------------------------------------------------------
// lpdc_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lpdc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpdc_pkg::MUL_A_W-1:0]  mcand,
	input  logic [lpdc_pkg::MUL_B_W-1:0]  mplier,
	output logic [lpdc_pkg::MUL_P_W-1:0]  prod,
	output lpdc_pkg::unit_stat_t          stat
);

	localparam int CNT_W = $clog2(lpdc_pkg::MUL_B_W);

	logic [lpdc_pkg::MUL_P_W-1:0] acc_q;
	logic [lpdc_pkg::MUL_A_W-1:0] mcand_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic [lpdc_pkg::MUL_A_W:0]   sum;

	// partial product added into the upper half, multiplier shifts out below
	assign sum = {1'b0, acc_q[lpdc_pkg::MUL_P_W-1:lpdc_pkg::MUL_B_W]}
		+ (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(lpdc_pkg::MUL_B_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= {{lpdc_pkg::MUL_A_W{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[lpdc_pkg::MUL_B_W-1:1]};
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == '0);

endmodule

FILE: hw/rtl/lpdc_div.sv
// ----------------------------------------------------------------------------
// lpdc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lpdc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpdc_pkg::DIV_N_W-1:0]  dividend,
	input  logic [lpdc_pkg::DIV_D_W-1:0]  divisor,
	output logic [lpdc_pkg::DIV_Q_W-1:0]  quo,
	output lpdc_pkg::unit_stat_t          stat
);

	localparam int CNT_W = $clog2(lpdc_pkg::DIV_N_W);

	logic [lpdc_pkg::DIV_N_W-1:0] dvd_q;
	logic [lpdc_pkg::DIV_D_W-1:0] rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic [lpdc_pkg::DIV_D_W:0]   trial;
	logic [lpdc_pkg::DIV_D_W:0]   diff;
	logic                         ge;

	// bring down the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[lpdc_pkg::DIV_N_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(lpdc_pkg::DIV_N_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[lpdc_pkg::DIV_D_W-1:0] : trial[lpdc_pkg::DIV_D_W-1:0];
			dvd_q <= {dvd_q[lpdc_pkg::DIV_N_W-2:0], ge};
		end
	end

	// quotient bits fill the dividend register from the bottom
	assign quo       = dvd_q[lpdc_pkg::DIV_Q_W-1:0];
	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == '0);

endmodule

FILE: hw/rtl/lift_position_drive_controller.sv
// ----------------------------------------------------------------------------
// lift_position_drive_controller
// per-tick lift position loop: encoder count and rate in, q15 motor drive out
// ----------------------------------------------------------------------------
// One request per control tick carries the raw encoder count and rate; one
// result comes back with the q15 drive, the position used, and the hold and
// zeroing flags. The block works on one request at a time. After acceptance it
// forms the position, the error and its absolute value; in target mode the
// shared shift-add multiplier then forms gain times error, while bottom and
// top mode take full scale. When overspeed derating applies, the same
// multiplier forms the magnitude times the derating factor and the restoring
// divider divides it by the overspeed band. The block is ready for the next
// request in the cycle after the result is loaded.
// The output register holds a finished result while the next request is taken.
// Write the configuration registers through cfg_wr_en / cfg_index /
// cfg_wdata only while no request is in progress; the block itself does not
// enforce this. Writing the seek mode clears the hold count.
// ----------------------------------------------------------------------------
module lift_position_drive_controller #(
	parameter int HOLD_LIMIT     = 100,
	parameter int STILL_LIMIT    = 50,
	parameter int OVERSPEED_BAND = 1200
) (
	input  logic               clk,
	input  logic               arst_n,

	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,

	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] encoder_count,
	input  logic signed [16:0] encoder_rate,

	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] motor_power,
	output logic               hold_timed_out,
	output logic               zero_taken,
	output logic signed [31:0] lift_position
);

	localparam logic [6:0]  HOLD_LIM  = 7'(HOLD_LIMIT);
	localparam logic [5:0]  STILL_LIM = 6'(STILL_LIMIT);
	localparam logic [15:0] BAND      = 16'(OVERSPEED_BAND);

	// configuration registers
	logic [1:0]         seek_mode_q;
	logic signed [31:0] target_q;
	logic [15:0]        move_gain_q;
	logic [15:0]        hold_tol_q;
	logic [15:0]        speed_lim_q;

	// tick state
	logic [6:0]         hold_cnt_q;
	logic [5:0]         still_cnt_q;
	logic signed [31:0] zero_off_q;

	// sequencer and working registers
	lpdc_pkg::state_t   state_q, state_d;
	logic signed [31:0] count_q;
	logic signed [16:0] rate_q;
	logic signed [31:0] pos_q;
	logic signed [33:0] err_q;
	logic [23:0]        aerr_q;
	logic               hold_in_q;
	logic               neg_q;
	logic               cut_q;
	logic               derate_q;
	logic [15:0]        factor_q;
	logic [14:0]        mag_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] power_q;
	logic               timed_out_q;
	logic               taken_q;
	logic signed [31:0] pos_out_q;

	// serial units
	logic                          mul_start;
	logic [lpdc_pkg::MUL_A_W-1:0]  mul_a;
	logic [lpdc_pkg::MUL_B_W-1:0]  mul_b;
	logic [lpdc_pkg::MUL_P_W-1:0]  mul_p;
	lpdc_pkg::unit_stat_t          mul_stat;
	logic                          div_start;
	logic [lpdc_pkg::DIV_Q_W-1:0]  div_q;
	lpdc_pkg::unit_stat_t          div_stat;

	// combinational helpers
	logic               seek_full;
	logic               load_out;
	logic signed [32:0] pos_diff;
	logic signed [31:0] pos_sat;
	logic signed [33:0] err_d;
	logic [33:0]        aerr_full;
	logic [16:0]        arate;
	logic signed [17:0] os;
	logic [6:0]         hold_next;
	logic [5:0]         still_next;
	logic               timed_out;
	logic               calib;
	logic [14:0]        mag_fin;
	logic signed [15:0] power_d;

	// bottom and top modes drive full scale; the unused code acts as target mode
	assign seek_full = (seek_mode_q == lpdc_pkg::MODE_BOTTOM) ||
		(seek_mode_q == lpdc_pkg::MODE_TOP);

	// position = count - offset, saturated to 32 bits
	assign pos_diff = {count_q[31], count_q} - {zero_off_q[31], zero_off_q};
	always_comb begin
		if (pos_diff[32] != pos_diff[31]) begin
			pos_sat = pos_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			pos_sat = pos_diff[31:0];
		end
	end

	// error is exact in 34 bits
	assign err_d     = {{2{target_q[31]}}, target_q} - {{2{pos_q[31]}}, pos_q};
	assign aerr_full = err_q[33] ? 34'(-err_q) : 34'(err_q);

	// overspeed = |rate| - limit
	assign arate = rate_q[16] ? 17'(~rate_q + 17'sd1) : 17'(rate_q);
	assign os    = $signed({1'b0, arate}) - $signed({2'b0, speed_lim_q});

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			lpdc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lpdc_pkg::ST_POS;
				end
			end
			lpdc_pkg::ST_POS: state_d = lpdc_pkg::ST_ERR;
			lpdc_pkg::ST_ERR: state_d = lpdc_pkg::ST_ABS;
			lpdc_pkg::ST_ABS: begin
				state_d = seek_full ? lpdc_pkg::ST_MAG : lpdc_pkg::ST_MGO;
			end
			lpdc_pkg::ST_MGO: begin
				mul_start = 1'b1;
				state_d   = lpdc_pkg::ST_MUL1;
			end
			lpdc_pkg::ST_MUL1: begin
				if (mul_stat.last) begin
					state_d = lpdc_pkg::ST_MAG;
				end
			end
			lpdc_pkg::ST_MAG: begin
				// derating only in the band above the speed limit
				state_d = (derate_q && !cut_q) ? lpdc_pkg::ST_M2GO : lpdc_pkg::ST_DONE;
			end
			lpdc_pkg::ST_M2GO: begin
				mul_start = 1'b1;
				state_d   = lpdc_pkg::ST_MUL2;
			end
			lpdc_pkg::ST_MUL2: begin
				if (mul_stat.last) begin
					state_d = lpdc_pkg::ST_DGO;
				end
			end
			lpdc_pkg::ST_DGO: begin
				div_start = 1'b1;
				state_d   = lpdc_pkg::ST_DIV;
			end
			lpdc_pkg::ST_DIV: begin
				if (div_stat.last) begin
					state_d = lpdc_pkg::ST_DONE;
				end
			end
			lpdc_pkg::ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = lpdc_pkg::ST_IDLE;
				end
			end
			default: state_d = lpdc_pkg::ST_IDLE;
		endcase
	end

	// ---------------- serial units ----------------
	// first product: clipped |error| times gain; second: magnitude times factor
	assign mul_a = (state_q == lpdc_pkg::ST_M2GO) ? {9'b0, mag_q} : aerr_q;
	assign mul_b = (state_q == lpdc_pkg::ST_M2GO) ? factor_q : move_gain_q;

	lpdc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mplier (mul_b),
		.prod   (mul_p),
		.stat   (mul_stat)
	);

	lpdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[lpdc_pkg::DIV_N_W-1:0]),
		.divisor  (BAND),
		.quo      (div_q),
		.stat     (div_stat)
	);

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			count_q <= encoder_count;
			rate_q  <= encoder_rate;
		end
		if (state_q == lpdc_pkg::ST_POS) begin
			pos_q <= pos_sat;
		end
		if (state_q == lpdc_pkg::ST_ERR) begin
			err_q    <= err_d;
			cut_q    <= os > $signed({2'b0, BAND});
			derate_q <= os > 18'sd0;
			factor_q <= BAND - os[15:0];
		end
		if (state_q == lpdc_pkg::ST_ABS) begin
			// any error of 2^23 or more saturates the drive for a nonzero gain
			aerr_q    <= (|aerr_full[33:23]) ? 24'h80_0000 : aerr_full[23:0];
			hold_in_q <= (aerr_full[33:16] == '0) && (aerr_full[15:0] < hold_tol_q);
			neg_q     <= seek_full ? (seek_mode_q == lpdc_pkg::MODE_BOTTOM) : err_q[33];
		end
		if (state_q == lpdc_pkg::ST_MAG) begin
			if (seek_full) begin
				mag_q <= lpdc_pkg::FULL_SCALE;
			end else begin
				// product >> 8, clamped to full scale
				mag_q <= (|mul_p[39:23]) ? lpdc_pkg::FULL_SCALE : mul_p[22:8];
			end
		end
	end

	// ---------------- end of tick ----------------
	always_comb begin
		if (seek_full || !hold_in_q) begin
			hold_next = '0;
		end else begin
			hold_next = (hold_cnt_q == 7'h7f) ? hold_cnt_q : hold_cnt_q + 7'd1;
		end
		if (rate_q == '0) begin
			still_next = (still_cnt_q == 6'h3f) ? still_cnt_q : still_cnt_q + 6'd1;
		end else begin
			still_next = '0;
		end
		timed_out = hold_next >= HOLD_LIM;
		calib     = (seek_mode_q == lpdc_pkg::MODE_BOTTOM) && (still_next >= STILL_LIM);
		if (cut_q) begin
			mag_fin = '0;
		end else if (derate_q) begin
			mag_fin = div_q;
		end else begin
			mag_fin = mag_q;
		end
		if (timed_out) begin
			power_d = '0;
		end else if (neg_q) begin
			power_d = -$signed({1'b0, mag_fin});
		end else begin
			power_d = $signed({1'b0, mag_fin});
		end
	end

	// configuration registers and tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seek_mode_q <= lpdc_pkg::MODE_TARGET;
			target_q    <= '0;
			move_gain_q <= lpdc_pkg::GAIN_RESET;
			hold_tol_q  <= lpdc_pkg::TOL_RESET;
			speed_lim_q <= lpdc_pkg::SPEED_LIM_RESET;
			hold_cnt_q  <= '0;
			still_cnt_q <= '0;
			zero_off_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					lpdc_pkg::REG_SEEK_MODE: begin
						seek_mode_q <= cfg_wdata[1:0];
						hold_cnt_q  <= '0;
					end
					lpdc_pkg::REG_TARGET:    target_q    <= cfg_wdata;
					lpdc_pkg::REG_MOVE_GAIN: move_gain_q <= cfg_wdata[15:0];
					lpdc_pkg::REG_HOLD_TOL:  hold_tol_q  <= cfg_wdata[15:0];
					lpdc_pkg::REG_SPEED_LIM: speed_lim_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (load_out) begin
				hold_cnt_q  <= hold_next;
				still_cnt_q <= still_next;
				// calibration: in bottom mode, offset follows the count once the still count reaches STILL_LIMIT
				if (calib) begin
					zero_off_q <= count_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			power_q     <= power_d;
			timed_out_q <= timed_out;
			taken_q     <= calib && (still_next == STILL_LIM);
			pos_out_q   <= pos_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign motor_power    = power_q;
	assign hold_timed_out = timed_out_q;
	assign zero_taken     = taken_q;
	assign lift_position  = pos_out_q;

	// ---------------- assertions ----------------
	// a timed-out hold always gives zero drive
	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hold_timed_out |-> motor_power == 16'sd0)
		else $error("hold timeout with nonzero drive");

	// drive never reaches the most negative code
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> motor_power != 16'sh8000)
		else $error("drive outside full scale");

	// the multiplier only runs while the sequencer waits on it
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.busy |-> (state_q == lpdc_pkg::ST_MUL1 || state_q == lpdc_pkg::ST_MUL2))
		else $error("multiplier busy outside its states");

	// the divider only runs in its own state
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == lpdc_pkg::ST_DIV)
		else $error("divider busy outside its state");

endmodule
